FILE: rtl/core/source_health_monitor_assert.svh
// Assertion macros for the source health monitor RTL.
// Included by modules that check their own logic; depends on nothing else.
`ifndef SOURCE_HEALTH_MONITOR_ASSERT_SVH
`define SOURCE_HEALTH_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("source health monitor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("source health monitor check failed");

`endif

FILE: rtl/core/shm_pkg.sv
// Shared types and constants for the source health monitor.
// No dependencies; used by the channel interfaces and the top level.
package shm_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned EV_W   = 6;
  localparam int unsigned MS_W   = 32;
  localparam int unsigned DTS_W  = 64;
  localparam int unsigned ERR_W  = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART   = 3'd0,
    CMD_TRANSPORT = 3'd1,
    CMD_MEDIA     = 3'd2,
    CMD_CONTAINER = 3'd3,
    CMD_TRACKS    = 3'd4,
    CMD_EVALUATE  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    REG_FAILURE_TIMEOUT  = 2'd0,
    REG_RECOVERY_TIMEOUT = 2'd1,
    REG_REQUIRED_MASK    = 2'd2
  } reg_e;

  // Evidence bit positions.
  localparam int unsigned EV_TRANSPORT = 0;
  localparam int unsigned EV_DATA      = 1;
  localparam int unsigned EV_MEDIA     = 2;
  localparam int unsigned EV_TS        = 3;
  localparam int unsigned EV_CONTAINER = 4;
  localparam int unsigned EV_TRACKS    = 5;

  localparam logic [MS_W-1:0] FAILURE_TIMEOUT_RST  = 32'd5000;
  localparam logic [MS_W-1:0] RECOVERY_TIMEOUT_RST = 32'd5000;
  localparam logic [EV_W-1:0] REQUIRED_MASK_RST    = 6'h3f;
  localparam logic [EV_W-1:0] EVIDENCE_RST         = 6'h10;

endpackage

FILE: rtl/core/shm_if.sv
// Valid/ready channel interfaces for source health monitor events and results.
// Depends on shm_pkg for field widths.
interface shm_in_if;
  import shm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [MS_W-1:0]   now_ms;
  logic              flag;
  logic signed [DTS_W-1:0] frame_dts;
  logic [ERR_W-1:0]  error_total;

  modport source (output valid, cmd, now_ms, flag, frame_dts, error_total, input ready);
  modport sink   (input valid, cmd, now_ms, flag, frame_dts, error_total, output ready);
endinterface

interface shm_out_if;
  import shm_pkg::*;

  logic             valid;
  logic             ready;
  logic             healthy;
  logic             eligible;
  logic [EV_W-1:0]  evidence_bits;
  logic [CNT_W-1:0] transition_count;
  logic [MS_W-1:0]  unhealthy_time;

  modport source (output valid, healthy, eligible, evidence_bits, transition_count,
                  unhealthy_time, input ready);
  modport sink   (input valid, healthy, eligible, evidence_bits, transition_count,
                  unhealthy_time, output ready);
endinterface

FILE: rtl/core/source_health_monitor.sv
// Source health monitor top level: event register, state update, result register.
// Depends on shm_pkg, shm_if.sv and source_health_monitor_assert.svh.
//
// Channel  Dir  Handshake          Contents
// in_i     in   valid/ready        cmd, now_ms, flag, frame_dts, error_total
// out_o    out  valid/ready        healthy, eligible, evidence_bits, transition_count,
//                                  unhealthy_time
// apb      in   psel/penable       timeout and mask registers, pready always high
//
// One event per cycle sustained while results are taken; each event passes through
// the event register and then the result register, from which its result can
// transfer on the output.
// The state update between them is a handful of 32-bit subtract-and-compare paths.
// A full result register that is not taken stalls the event register, and the input
// stays ready while either stage can move. Reset loads the post-restart state at
// time zero at once; there is no clearing pass.
`include "source_health_monitor_assert.svh"

module source_health_monitor #(
  parameter int unsigned TIME_BITS = shm_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  shm_in_if.sink                      in_i,
  shm_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [shm_pkg::APB_AW-1:0]  paddr,
  input  logic [shm_pkg::APB_DW-1:0]  pwdata,
  output logic [shm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import shm_pkg::*;

  localparam int unsigned CW = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

  typedef logic [TIME_BITS-1:0] tm_t;

  // Configuration registers.
  logic [MS_W-1:0] fail_to_q, recov_to_q;
  logic [EV_W-1:0] req_mask_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_to_q  <= FAILURE_TIMEOUT_RST;
      recov_to_q <= RECOVERY_TIMEOUT_RST;
      req_mask_q <= REQUIRED_MASK_RST;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[3:2]))
        REG_FAILURE_TIMEOUT:  fail_to_q  <= pwdata;
        REG_RECOVERY_TIMEOUT: recov_to_q <= pwdata;
        REG_REQUIRED_MASK:    req_mask_q <= pwdata[EV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_FAILURE_TIMEOUT:  prdata = fail_to_q;
      REG_RECOVERY_TIMEOUT: prdata = recov_to_q;
      REG_REQUIRED_MASK:    prdata = APB_DW'(req_mask_q);
      default:              prdata = '0;
    endcase
  end

  // Event register.
  logic                    in_valid_q;
  logic [CMD_W-1:0]        cmd_q;
  tm_t                     now_q;
  logic                    flag_q;
  logic signed [DTS_W-1:0] dts_q;
  logic [ERR_W-1:0]        errs_q;

  logic out_valid_q;
  logic fire;

  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.cmd;
      now_q  <= TIME_BITS'(in_i.now_ms);
      flag_q <= in_i.flag;
      dts_q  <= in_i.frame_dts;
      errs_q <= in_i.error_total;
    end
  end

  // Source state.
  logic [EV_W-1:0]         ev_q, ev_d;
  tm_t                     media_t_q, media_t_d;
  tm_t                     dts_t_q, dts_t_d;
  logic signed [DTS_W-1:0] hi_dts_q, hi_dts_d;
  logic [ERR_W-1:0]        errs_seen_q, errs_seen_d;
  tm_t                     err_t_q, err_t_d;
  logic                    healthy_q, healthy_d;
  logic                    eligible_q, eligible_d;
  tm_t                     hs_q, hs_d;
  logic                    hs_valid_q, hs_valid_d;
  tm_t                     us_q, us_d;
  logic [CNT_W-1:0]        trans_q, trans_d;

  tm_t             el_media, el_dts, el_err, el_hs;
  tm_t             hs_eff;
  logic            up;
  logic            media_ok, dts_ok, err_clean, full;
  logic [EV_W-1:0] ev_eval;

  // Elapsed times and evaluate-time evidence, computed for every event.
  always_comb begin
    up        = ev_q[EV_TRANSPORT];
    el_media  = now_q - media_t_q;
    el_dts    = now_q - dts_t_q;
    el_err    = now_q - err_t_q;
    hs_eff    = hs_valid_q ? hs_q : now_q;
    el_hs     = now_q - hs_eff;
    media_ok  = up && (CW'(el_media) <= CW'(fail_to_q));
    dts_ok    = up && (CW'(el_dts) <= CW'(fail_to_q));
    err_clean = CW'(el_err) >= CW'(recov_to_q);
    ev_eval   = ev_q;
    ev_eval[EV_DATA]  = media_ok;
    ev_eval[EV_MEDIA] = media_ok;
    ev_eval[EV_TS]    = dts_ok;
    if (!ev_q[EV_CONTAINER] && err_clean) begin
      ev_eval[EV_CONTAINER] = 1'b1;
    end
    full = (ev_eval & req_mask_q) == req_mask_q;
  end

  always_comb begin
    ev_d        = ev_q;
    media_t_d   = media_t_q;
    dts_t_d     = dts_t_q;
    hi_dts_d    = hi_dts_q;
    errs_seen_d = errs_seen_q;
    err_t_d     = err_t_q;
    healthy_d   = healthy_q;
    eligible_d  = eligible_q;
    hs_d        = hs_q;
    hs_valid_d  = hs_valid_q;
    us_d        = us_q;
    trans_d     = trans_q;
    unique case (cmd_e'(cmd_q))
      CMD_RESTART: begin
        ev_d        = EVIDENCE_RST;
        media_t_d   = now_q;
        dts_t_d     = now_q;
        hi_dts_d    = '0;
        errs_seen_d = '0;
        err_t_d     = '0;
        healthy_d   = 1'b1;
        eligible_d  = 1'b1;
        hs_d        = now_q;
        hs_valid_d  = 1'b1;
        us_d        = '0;
        trans_d     = '0;
      end
      CMD_TRANSPORT: begin
        if (flag_q) begin
          ev_d[EV_TRANSPORT] = 1'b1;
        end else begin
          // Transport loss fails the source at once, even if already failed.
          ev_d       = '0;
          hs_d       = '0;
          hs_valid_d = 1'b0;
          us_d       = now_q;
          if (healthy_q || eligible_q) begin
            trans_d = trans_q + 1'b1;
          end
          healthy_d  = 1'b0;
          eligible_d = 1'b0;
        end
      end
      CMD_MEDIA: begin
        media_t_d = now_q;
        if (dts_q > hi_dts_q) begin
          hi_dts_d = dts_q;
          dts_t_d  = now_q;
        end
      end
      CMD_CONTAINER: begin
        if (errs_q > errs_seen_q) begin
          errs_seen_d          = errs_q;
          err_t_d              = now_q;
          ev_d[EV_CONTAINER]   = 1'b0;
        end
      end
      CMD_TRACKS: begin
        ev_d[EV_TRACKS] = flag_q;
      end
      CMD_EVALUATE: begin
        ev_d = ev_eval;
        if (full) begin
          hs_d       = hs_eff;
          hs_valid_d = 1'b1;
          if (!healthy_q && (CW'(el_hs) >= CW'(recov_to_q))) begin
            healthy_d = 1'b1;
            trans_d   = trans_q + 1'b1;
            us_d      = '0;
          end
        end else if (healthy_q) begin
          healthy_d  = 1'b0;
          trans_d    = trans_q + 1'b1;
          hs_d       = '0;
          hs_valid_d = 1'b0;
          us_d       = now_q;
        end
        eligible_d = healthy_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q        <= EVIDENCE_RST;
      media_t_q   <= '0;
      dts_t_q     <= '0;
      hi_dts_q    <= '0;
      errs_seen_q <= '0;
      err_t_q     <= '0;
      healthy_q   <= 1'b1;
      eligible_q  <= 1'b1;
      hs_q        <= '0;
      hs_valid_q  <= 1'b1;
      us_q        <= '0;
      trans_q     <= '0;
    end else if (fire) begin
      ev_q        <= ev_d;
      media_t_q   <= media_t_d;
      dts_t_q     <= dts_t_d;
      hi_dts_q    <= hi_dts_d;
      errs_seen_q <= errs_seen_d;
      err_t_q     <= err_t_d;
      healthy_q   <= healthy_d;
      eligible_q  <= eligible_d;
      hs_q        <= hs_d;
      hs_valid_q  <= hs_valid_d;
      us_q        <= us_d;
      trans_q     <= trans_d;
    end
  end

  // Result register.
  logic             res_healthy_q, res_eligible_q;
  logic [EV_W-1:0]  res_ev_q;
  logic [CNT_W-1:0] res_trans_q;
  logic [MS_W-1:0]  res_us_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_healthy_q  <= healthy_d;
      res_eligible_q <= eligible_d;
      res_ev_q       <= ev_d;
      res_trans_q    <= trans_d;
      res_us_q       <= MS_W'(us_d);
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.healthy          = res_healthy_q;
  assign out_o.eligible         = res_eligible_q;
  assign out_o.evidence_bits    = res_ev_q;
  assign out_o.transition_count = res_trans_q;
  assign out_o.unhealthy_time   = res_us_q;

  // A healthy source always has a recovery start and no failure time.
  `SHM_ASSERT_IMP(a_healthy_has_start, clk_i, rst_ni, healthy_q, hs_valid_q && (us_q == '0))
  // Eligibility follows health after every kind of event.
  `SHM_ASSERT_IMP(a_elig_tracks_health, clk_i, rst_ni, out_valid_q,
                  res_eligible_q == res_healthy_q)
  // The transition counter only moves when an event is processed.
  `SHM_ASSERT_NXT(a_trans_stable, clk_i, rst_ni, !fire, $stable(trans_q))
  // The input is held off only when both stages are full and the output stalls.
  `SHM_ASSERT_IMP(a_ready_only_stall, clk_i, rst_ni, !in_i.ready,
                  in_valid_q && out_valid_q && !out_o.ready)

endmodule
